// ===== design/kv_store_cas_dedup_defines.svh =====
// Assertion macros for the key/value store.
// Used by the top level only; no other dependencies.
`ifndef KV_STORE_CAS_DEDUP_DEFINES_SVH
`define KV_STORE_CAS_DEDUP_DEFINES_SVH
// implication checked on every edge outside reset
`define KV_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("label failed");
// implication checked in the next cycle
`define KV_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("label failed");
`endif

// ===== design/kvs_pkg.sv =====
// Shared types and codes for the key/value store.
// No dependencies.
package kvs_pkg;
    localparam logic [2:0] CMD_GET = 3'd0;
    localparam logic [2:0] CMD_PUT = 3'd1;
    localparam logic [2:0] CMD_DEL = 3'd2;
    localparam logic [2:0] CMD_CAS = 3'd3;
    localparam logic [2:0] CMD_CAD = 3'd4;

    localparam logic [1:0] ST_EXEC   = 2'd0;
    localparam logic [1:0] ST_REPLAY = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // search token passed cell to cell
    typedef struct packed {
        logic        act;
        logic [63:0] key;
        logic        found;
        logic [63:0] val;
        logic        has_free;
    } kvs_tok_t;

    // write command broadcast to all cells
    typedef struct packed {
        logic        wr;
        logic        erase;
        logic [63:0] key;
        logic [63:0] val;
    } kvs_upd_t;
endpackage

// ===== design/kv_store_cas_dedup.sv =====
// Key/value store with compare-and-swap and per-client duplicate suppression.
// Channels: s_axis request words in, m_axis response words out.
// A request is taken only when the block is idle. A client record is read
// first; a stale request is dropped, an equal seqnum replays the record.
// Otherwise a search token walks the chain of TABLE_DEPTH cells, one cell
// per cycle. Hit flags latched in each cell and the free flags pick the
// entry to update with a fixed-priority select.
// The response sits in an output register until m_axis_tready; the next
// request may be taken meanwhile but waits before the record read until
// the register has been taken.
// Reset empties the table and forgets all clients.
// A stalled receiver holds the response; one more request is taken, then
// the input stalls.
`include "kv_store_cas_dedup_defines.svh"
module kv_store_cas_dedup #(
    parameter int TABLE_DEPTH = 64,
    parameter int NUM_CLIENTS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[2:0] client[6:3] seqnum[38:7] key[102:39] value[166:103]
    // expected_present[167] expected_value[231:168]
    input  logic [231:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0] client_out[5:2] seqnum_out[37:6] key_out[101:38]
    // old_present[102] old_value[166:103] new_present[167] new_value[231:168]
    output logic [231:0] m_axis_tdata
);
    localparam int CW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_REC  = 3'd1;
    localparam logic [2:0] S_SRCH = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  cmd_reg;
    logic [3:0]  cl_reg;
    logic [31:0] seq_reg;
    logic [63:0] key_reg, val_reg, expv_reg;
    logic        expp_reg;
    logic [CNTW-1:0] cnt_reg;

    logic [NUM_CLIENTS-1:0] seen_reg;
    logic [31:0] rec_seq [NUM_CLIENTS];
    logic [63:0] rec_key [NUM_CLIENTS];
    logic        rec_op  [NUM_CLIENTS];
    logic [63:0] rec_ov  [NUM_CLIENTS];
    logic        rec_np  [NUM_CLIENTS];
    logic [63:0] rec_nv  [NUM_CLIENTS];
    logic [31:0] rd_seq_reg;
    logic [63:0] rd_key_reg, rd_ov_reg, rd_nv_reg;
    logic        rd_op_reg, rd_np_reg, rd_seen_reg;

    logic [231:0] out_reg;
    logic         ovalid_reg;

    kvs_pkg::kvs_tok_t tok [TABLE_DEPTH+1];
    kvs_pkg::kvs_tok_t tok_head;
    kvs_pkg::kvs_upd_t upd;
    logic [TABLE_DEPTH-1:0] free_v, hit_v, sel_v;
    logic [CW-1:0] cidx;

    assign cidx = CW'(cl_reg);
    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb begin
        tok_head = '0;
        tok_head.act = (state_reg == S_SRCH) && (cnt_reg == '0);
        tok_head.key = key_reg;
    end

    assign tok[0] = tok_head;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            kvs_cell u_cell (
                .aclk(aclk), .aresetn(aresetn), .tok_i(tok[g]), .tok_o(tok[g+1]),
                .sel_i(sel_v[g]), .upd_i(upd), .free_o(free_v[g]), .hit_o(hit_v[g])
            );
        end
    endgenerate

    // end of chain result
    kvs_pkg::kvs_tok_t res;
    logic do_wr, do_er, full;
    logic [63:0] nv;
    logic        np;
    logic [TABLE_DEPTH-1:0] first_free;
    assign res = tok[TABLE_DEPTH];
    assign first_free = free_v & (~free_v + TABLE_DEPTH'(1));

    always_comb begin
        do_wr = 1'b0;
        do_er = 1'b0;
        case (cmd_reg)
            kvs_pkg::CMD_PUT: do_wr = 1'b1;
            kvs_pkg::CMD_DEL: do_er = 1'b1;
            kvs_pkg::CMD_CAS:
                do_wr = (res.found == expp_reg) && (!res.found || res.val == expv_reg);
            kvs_pkg::CMD_CAD: do_er = res.found && res.val == val_reg;
            default: ;
        endcase
        full = do_wr && !res.found && !res.has_free;
        np = res.found;
        nv = res.found ? res.val : 64'd0;
        if (do_wr) begin
            np = 1'b1;
            nv = val_reg;
        end else if (do_er) begin
            np = 1'b0;
            nv = 64'd0;
        end
        upd.wr = do_wr && !full;
        upd.erase = do_er && res.found;
        upd.key = key_reg;
        upd.val = val_reg;
        if (state_reg != S_EXEC)
            sel_v = '0;
        else if (res.found)
            sel_v = hit_v;
        else
            sel_v = first_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) state_next = S_REC;
            S_REC: begin
                if (ovalid_reg && !m_axis_tready) state_next = S_REC;
                else if ({28'd0, cl_reg} >= NUM_CLIENTS) state_next = S_IDLE;
                else state_next = S_OUT;
            end
            S_OUT: begin
                if (rd_seen_reg && rd_seq_reg >= seq_reg) state_next = S_IDLE;
                else state_next = S_SRCH;
            end
            S_SRCH: if (cnt_reg == CNTW'(TABLE_DEPTH - 1)) state_next = S_EXEC;
            S_EXEC: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            seen_reg <= '0;
            ovalid_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (ovalid_reg && m_axis_tready) ovalid_reg <= 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                cmd_reg  <= s_axis_tdata[2:0];
                cl_reg   <= s_axis_tdata[6:3];
                seq_reg  <= s_axis_tdata[38:7];
                key_reg  <= s_axis_tdata[102:39];
                val_reg  <= s_axis_tdata[166:103];
                expp_reg <= s_axis_tdata[167];
                expv_reg <= s_axis_tdata[231:168];
            end
            if (state_reg == S_REC) begin
                rd_seen_reg <= seen_reg[cidx];
                rd_seq_reg <= rec_seq[cidx];
                rd_key_reg <= rec_key[cidx];
                rd_op_reg <= rec_op[cidx];
                rd_ov_reg <= rec_ov[cidx];
                rd_np_reg <= rec_np[cidx];
                rd_nv_reg <= rec_nv[cidx];
            end
            if (state_reg == S_OUT && rd_seen_reg && rd_seq_reg == seq_reg) begin
                ovalid_reg <= 1'b1;
                out_reg <= {(rd_np_reg ? rd_nv_reg : 64'd0), rd_np_reg,
                            (rd_op_reg ? rd_ov_reg : 64'd0), rd_op_reg,
                            rd_key_reg, seq_reg, cl_reg, kvs_pkg::ST_REPLAY};
            end
            if (state_reg == S_SRCH) cnt_reg <= cnt_reg + CNTW'(1);
            else cnt_reg <= '0;
            if (state_reg == S_EXEC) begin
                ovalid_reg <= 1'b1;
                if (full) begin
                    out_reg <= {64'd0, 1'b0, 64'd0, 1'b0, key_reg, seq_reg, cl_reg,
                                kvs_pkg::ST_FULL};
                end else begin
                    out_reg <= {nv, np, (res.found ? res.val : 64'd0), res.found,
                                key_reg, seq_reg, cl_reg, kvs_pkg::ST_EXEC};
                    seen_reg[cidx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_EXEC && !full) begin
            rec_seq[cidx] <= seq_reg;
            rec_key[cidx] <= key_reg;
            rec_op[cidx]  <= res.found;
            rec_ov[cidx]  <= res.found ? res.val : 64'd0;
            rec_np[cidx]  <= np;
            rec_nv[cidx]  <= nv;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_reg;

    `KV_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg != S_IDLE, !s_axis_tready)
    `KV_ASSERT_IMP(a_sel_onehot, aclk, aresetn, 1'b1, $onehot0(sel_v))
    `KV_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))
endmodule

// ===== design/kvs_cell.sv =====
// One table entry: compares the passing search token and applies updates.
// Depends on kvs_pkg.
module kvs_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  kvs_pkg::kvs_tok_t tok_i,
    output kvs_pkg::kvs_tok_t tok_o,
    input  logic              sel_i,
    input  kvs_pkg::kvs_upd_t upd_i,
    output logic              free_o,
    output logic              hit_o
);
    logic        valid_reg;
    logic [63:0] key_reg;
    logic [63:0] val_reg;
    kvs_pkg::kvs_tok_t tok_reg;
    kvs_pkg::kvs_tok_t tok_next;
    logic        hit_reg;
    logic        match;

    assign match = tok_i.act && !tok_i.found && valid_reg && key_reg == tok_i.key;

    always_comb begin
        tok_next = tok_i;
        if (match) begin
            tok_next.found = 1'b1;
            tok_next.val = val_reg;
        end
        if (tok_i.act && !valid_reg)
            tok_next.has_free = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg <= '0;
            hit_reg <= 1'b0;
        end else begin
            tok_reg <= tok_next;
            if (tok_i.act)
                hit_reg <= match;
            if (sel_i) begin
                if (upd_i.erase) begin
                    valid_reg <= 1'b0;
                end else if (upd_i.wr) begin
                    valid_reg <= 1'b1;
                    key_reg <= upd_i.key;
                    val_reg <= upd_i.val;
                end
            end
        end
    end

    assign tok_o  = tok_reg;
    assign free_o = !valid_reg;
    assign hit_o  = hit_reg;
endmodule

// ===== test/tb_kv_store_cas_dedup.sv =====
// Self-checking testbench for kv_store_cas_dedup: key/value table, CAS/CAD and
// per-client duplicate suppression, checked word by word against a predictor.
// Depends on kvs_pkg and the kv_store_cas_dedup top level.
module tb_kv_store_cas_dedup;
    localparam int DEPTH   = 64;
    localparam int CLIENTS = 16;
    localparam int WDOG    = 20000;

    typedef struct packed {
        logic [63:0] exp_value;
        logic        expected_present;
        logic [63:0] value;
        logic [63:0] key;
        logic [31:0] seqnum;
        logic [3:0]  client;
        logic [2:0]  command;
    } req_t;

    typedef struct packed {
        logic [63:0] new_value;
        logic        new_present;
        logic [63:0] prev_value;
        logic        old_present;
        logic [63:0] key_out;
        logic [31:0] seqnum_out;
        logic [3:0]  client_out;
        logic [1:0]  status;
    } rsp_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [231:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [231:0] m_axis_tdata;

    kv_store_cas_dedup dut (.*);

    initial forever #2 aclk = ~aclk;

    // predictor state
    logic        tbl_valid [DEPTH];
    logic [63:0] tbl_key   [DEPTH];
    logic [63:0] tbl_val   [DEPTH];
    logic        cli_seen  [CLIENTS];
    logic [31:0] cli_seq   [CLIENTS];
    rsp_t        cli_rsp   [CLIENTS];

    rsp_t        pending_rsp [$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    bit          hold_off = 0;
    logic [31:0] next_seq [CLIENTS];
    logic [63:0] key_pool [8];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("mismatch %s: got %0h expected %0h", what, got, exp);
        errors++;
    endtask

    function automatic void predict_response(input req_t r);
        int          hit, free_slot;
        bit          found, has_free, do_write, do_erase;
        rsp_t        o;
        found = 0; has_free = 0; do_write = 0; do_erase = 0;
        hit = 0; free_slot = 0;
        if (cli_seen[r.client] && cli_seq[r.client] >= r.seqnum) begin
            if (cli_seq[r.client] == r.seqnum) begin
                o = cli_rsp[r.client];
                o.status = kvs_pkg::ST_REPLAY;
                pending_rsp.push_back(o);
            end
            return;
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (tbl_valid[i]) begin
                if (!found && tbl_key[i] == r.key) begin
                    found = 1'b1;
                    hit = i;
                end
            end else if (!has_free) begin
                has_free = 1'b1;
                free_slot = i;
            end
        end
        o = '0;
        o.client_out = r.client;
        o.seqnum_out = r.seqnum;
        o.key_out = r.key;
        o.old_present = found;
        o.prev_value = found ? tbl_val[hit] : 64'd0;
        o.new_present = o.old_present;
        o.new_value = o.prev_value;
        case (r.command)
            kvs_pkg::CMD_PUT: do_write = 1'b1;
            kvs_pkg::CMD_DEL: do_erase = 1'b1;
            kvs_pkg::CMD_CAS: do_write = (found == r.expected_present) &&
                                         (!found || o.prev_value == r.exp_value);
            kvs_pkg::CMD_CAD: do_erase = found && o.prev_value == r.value;
            default: ;
        endcase
        if (do_write) begin
            if (!found) begin
                if (!has_free) begin
                    o = '0;
                    o.status = kvs_pkg::ST_FULL;
                    o.client_out = r.client;
                    o.seqnum_out = r.seqnum;
                    o.key_out = r.key;
                    pending_rsp.push_back(o);
                    return;
                end
                hit = free_slot;
                tbl_valid[hit] = 1'b1;
                tbl_key[hit] = r.key;
            end
            tbl_val[hit] = r.value;
            o.new_present = 1'b1;
            o.new_value = r.value;
        end else if (do_erase) begin
            if (found) tbl_valid[hit] = 1'b0;
            o.new_present = 1'b0;
            o.new_value = 64'd0;
        end
        o.status = kvs_pkg::ST_EXEC;
        cli_seen[r.client] = 1'b1;
        cli_seq[r.client] = r.seqnum;
        cli_rsp[r.client] = o;
        pending_rsp.push_back(o);
    endfunction

    task automatic send_request(input req_t r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_axis_tvalid <= 1;
        s_axis_tdata <= 232'(r);
        do @(posedge aclk); while (!s_axis_tready);
        predict_response(r);
    endtask

    function automatic req_t make_req(input logic [2:0] cmd, input logic [3:0] cl,
                                      input logic [63:0] k, input logic [63:0] v);
        req_t r;
        r = '0;
        r.command = cmd;
        r.client = cl;
        r.seqnum = next_seq[cl];
        next_seq[cl] = next_seq[cl] + 32'd1;
        r.key = k;
        r.value = v;
        return r;
    endfunction

    task automatic test_directed();
        req_t r;
        r = make_req(kvs_pkg::CMD_GET, 4'd0, '0, '0);            send_request(r);
        r = make_req(kvs_pkg::CMD_PUT, 4'd1, '1, '1);            send_request(r);
        r = make_req(kvs_pkg::CMD_PUT, 4'd1, 64'd0, 64'h8000_0000_0000_0001);
        send_request(r);
        r = make_req(kvs_pkg::CMD_GET, 4'd15, '1, '0);           send_request(r);
        send_request(r);                                         // replay
        r.command = kvs_pkg::CMD_DEL; r.key = 64'd5;             send_request(r); // replay
        r.seqnum = r.seqnum - 32'd1;                             send_request(r); // stale
        r = make_req(kvs_pkg::CMD_CAS, 4'd2, '1, 64'd7);
        r.expected_present = 1'b1; r.exp_value = '1;             send_request(r);
        r = make_req(kvs_pkg::CMD_CAS, 4'd2, '1, 64'd9);
        r.expected_present = 1'b1; r.exp_value = '1;             send_request(r); // mismatch
        r = make_req(kvs_pkg::CMD_CAS, 4'd2, 64'h33, 64'd1);     send_request(r); // absent
        r = make_req(kvs_pkg::CMD_CAD, 4'd3, 64'h33, 64'd2);     send_request(r);
        r = make_req(kvs_pkg::CMD_CAD, 4'd3, 64'h33, 64'd1);     send_request(r);
        r = make_req(kvs_pkg::CMD_DEL, 4'd3, '1, '0);            send_request(r);
        r = make_req(kvs_pkg::CMD_DEL, 4'd3, '1, '0);            send_request(r);
        r = make_req(3'd7, 4'd4, 64'd0, '0);                     send_request(r);
        r = make_req(3'd5, 4'd4, 64'd0, '0);                     send_request(r);
        r = make_req(kvs_pkg::CMD_GET, 4'd14, '0, '0);
        r.seqnum = 32'hFFFF_FFFF;                                send_request(r);
        r.seqnum = 32'h0;                                        send_request(r); // no wrap
    endtask

    // fill the table, hit table-full, retry the same seqnum after a delete
    task automatic test_table_full();
        req_t r;
        for (int i = 0; i < DEPTH + 4; i++) begin
            r = make_req(kvs_pkg::CMD_PUT, 4'd5, 64'h1000 + 64'(i), 64'($urandom()));
            send_request(r);
        end
        r = make_req(kvs_pkg::CMD_CAS, 4'd6, 64'hABCD, 64'd3);   send_request(r);
        send_request(r);
        r = make_req(kvs_pkg::CMD_DEL, 4'd7, 64'h1000, '0);      send_request(r);
        r = make_req(kvs_pkg::CMD_CAS, 4'd6, 64'hABCD, 64'd3);
        r.seqnum = next_seq[6] - 32'd2;                          send_request(r);
        for (int i = 0; i < DEPTH; i++) begin
            r = make_req(kvs_pkg::CMD_DEL, 4'd5, 64'h1000 + 64'(i), '0);
            send_request(r);
        end
        r = make_req(kvs_pkg::CMD_DEL, 4'd5, 64'hABCD, '0);      send_request(r);
    endtask

    task automatic test_random(input int count);
        req_t r;
        logic [63:0] k;
        for (int n = 0; n < count; n++) begin
            k = ($urandom_range(0, 9) == 0) ? {$urandom(), $urandom()}
                                             : key_pool[$urandom_range(0, 7)];
            r = make_req(3'($urandom_range(0, 7) == 7 ? $urandom_range(5, 7)
                                                       : $urandom_range(0, 4)),
                         4'($urandom_range(0, 15)), k,
                         $urandom_range(0, 1) ? 64'($urandom_range(0, 3))
                                              : {$urandom(), $urandom()});
            r.expected_present = 1'($urandom_range(0, 1));
            r.exp_value = $urandom_range(0, 1) ? 64'($urandom_range(0, 3))
                                               : {$urandom(), $urandom()};
            case ($urandom_range(0, 9))
                0: r.seqnum = r.seqnum - 32'd1;                  // replay
                1: r.seqnum = r.seqnum - 32'($urandom_range(2, 5)); // stale
                2: begin
                    r.seqnum = r.seqnum + 32'($urandom());
                    next_seq[r.client] = r.seqnum + 32'd1;
                end
                default: ;
            endcase
            if (n == count / 2) hold_off = 1;
            send_request(r);
        end
    endtask

    // receiver stall pattern plus one long hold-off
    always @(posedge aclk) begin
        if (hold_off) begin
            m_axis_tready <= 0;
            repeat (600) @(posedge aclk);
            hold_off = 0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 7) < 5) || ($urandom_range(0, 63) == 0);
        end
    end

    always @(posedge aclk) begin
        rsp_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = rsp_t'(m_axis_tdata);
            if (pending_rsp.size() == 0) begin
                report("unexpected word", got.key_out, 64'd0);
            end else begin
                want = pending_rsp.pop_front();
                if (got.status != want.status)
                    report("status", 64'(got.status), 64'(want.status));
                if (got.client_out != want.client_out)
                    report("client_out", 64'(got.client_out), 64'(want.client_out));
                if (got.seqnum_out != want.seqnum_out)
                    report("seqnum_out", 64'(got.seqnum_out), 64'(want.seqnum_out));
                if (got.key_out != want.key_out) report("key_out", got.key_out, want.key_out);
                if (got.old_present != want.old_present)
                    report("old_present", 64'(got.old_present), 64'(want.old_present));
                if (got.prev_value != want.prev_value)
                    report("prev_value", got.prev_value, want.prev_value);
                if (got.new_present != want.new_present)
                    report("new_present", 64'(got.new_present), 64'(want.new_present));
                if (got.new_value != want.new_value)
                    report("new_value", got.new_value, want.new_value);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            tbl_valid[i] = 1'b0; tbl_key[i] = '0; tbl_val[i] = '0;
        end
        for (int i = 0; i < CLIENTS; i++) begin
            cli_seen[i] = 1'b0; cli_seq[i] = '0; cli_rsp[i] = '0;
            next_seq[i] = $urandom_range(1, 1000);
        end
        foreach (key_pool[i]) key_pool[i] = (i < 4) ? 64'(i) : {$urandom(), $urandom()};
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_directed();
        test_table_full();
        test_random(1280);
        s_axis_tvalid <= 0;
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (DEPTH * 3) @(posedge aclk);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/kvs_pkg.sv
design/kvs_cell.sv
design/kv_store_cas_dedup.sv
test/tb_kv_store_cas_dedup.sv
